/* rtl/pdfe_pkg.sv */
package pdfe_pkg;

    // Token modes as written to the mode register; the fourth code acts as name mode.
    localparam logic [1:0] MODE_LITERAL = 2'd0;
    localparam logic [1:0] MODE_HEX     = 2'd1;
    localparam logic [1:0] MODE_NAME    = 2'd2;

    // Register map.
    localparam logic [1:0] ADDR_TOKEN_MODE = 2'd0;

    // Longest expansion of one input byte, and the width of a character count.
    localparam int MAX_CHARS = 6;
    localparam int CNT_W     = 3;

    // Default depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Characters used by the encoder.
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LT        = 8'h3C;
    localparam logic [7:0] CH_GT        = 8'h3E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TILDE     = 8'h7E;

    // Characters that one input item expands to, in output order.
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [CNT_W-1:0]          cnt;
    } plan_t;

    // Head of the queue as the back part sees it.
    typedef struct packed {
        logic  valid;
        plan_t plan;
    } q_head_t;

    // Upper-case hex digit of a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = 8'h30 + {4'd0, d};
        end
        else
        begin
            r = 8'h37 + {4'd0, d};
        end
        return r;
    endfunction

endpackage

/* rtl/pdfe_front.sv */
module pdfe_front (
    input  logic                  in_valid,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    input  logic                  last_byte,
    input  logic [1:0]            token_mode,
    input  logic                  q_full,
    output logic                  in_ready,
    output logic                  push,
    output pdfe_pkg::plan_t       plan
);

    // An item is taken whenever the queue has room.
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Classify the byte and list the characters it expands to.
    always_comb
    begin
        logic [2:0] n;
        logic       name_esc;
        n    = '0;
        plan = '0;
        name_esc = (data_byte <= pdfe_pkg::CH_SPACE) || (data_byte > pdfe_pkg::CH_TILDE)
                || (data_byte == pdfe_pkg::CH_HASH) || (data_byte == pdfe_pkg::CH_PERCENT)
                || (data_byte == pdfe_pkg::CH_SLASH);
        unique case (token_mode)
            pdfe_pkg::MODE_LITERAL:
            begin
                if (first_byte)
                begin
                    plan.chars[n] = pdfe_pkg::CH_LPAREN;
                    n = n + 3'd1;
                end
                if (data_byte < pdfe_pkg::CH_SPACE)
                begin
                    // Control byte: backslash, zero and two octal digits.
                    plan.chars[n] = pdfe_pkg::CH_BACKSLASH;
                    n = n + 3'd1;
                    plan.chars[n] = pdfe_pkg::CH_ZERO;
                    n = n + 3'd1;
                    plan.chars[n] = pdfe_pkg::CH_ZERO + {5'd0, data_byte[5:3]};
                    n = n + 3'd1;
                    plan.chars[n] = pdfe_pkg::CH_ZERO + {5'd0, data_byte[2:0]};
                    n = n + 3'd1;
                end
                else if ((data_byte == pdfe_pkg::CH_LPAREN)
                      || (data_byte == pdfe_pkg::CH_RPAREN)
                      || (data_byte == pdfe_pkg::CH_BACKSLASH))
                begin
                    plan.chars[n] = pdfe_pkg::CH_BACKSLASH;
                    n = n + 3'd1;
                    plan.chars[n] = data_byte;
                    n = n + 3'd1;
                end
                else
                begin
                    plan.chars[n] = data_byte;
                    n = n + 3'd1;
                end
                if (last_byte)
                begin
                    plan.chars[n] = pdfe_pkg::CH_RPAREN;
                    n = n + 3'd1;
                end
            end
            pdfe_pkg::MODE_HEX:
            begin
                if (first_byte)
                begin
                    plan.chars[n] = pdfe_pkg::CH_LT;
                    n = n + 3'd1;
                end
                plan.chars[n] = pdfe_pkg::hex_digit(data_byte[7:4]);
                n = n + 3'd1;
                plan.chars[n] = pdfe_pkg::hex_digit(data_byte[3:0]);
                n = n + 3'd1;
                if (last_byte)
                begin
                    plan.chars[n] = pdfe_pkg::CH_GT;
                    n = n + 3'd1;
                end
            end
            default:
            begin
                // Name mode; the closing mark adds nothing here.
                if (first_byte)
                begin
                    plan.chars[n] = pdfe_pkg::CH_SLASH;
                    n = n + 3'd1;
                end
                if (name_esc)
                begin
                    plan.chars[n] = pdfe_pkg::CH_HASH;
                    n = n + 3'd1;
                    plan.chars[n] = pdfe_pkg::hex_digit(data_byte[7:4]);
                    n = n + 3'd1;
                    plan.chars[n] = pdfe_pkg::hex_digit(data_byte[3:0]);
                    n = n + 3'd1;
                end
                else
                begin
                    plan.chars[n] = data_byte;
                    n = n + 3'd1;
                end
            end
        endcase
        plan.cnt = n;
    end

endmodule

/* rtl/pdfe_queue.sv */
module pdfe_queue #(
    parameter int Depth = pdfe_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pdfe_pkg::plan_t       push_plan,
    output logic                  full,
    input  logic                  pop,
    output pdfe_pkg::q_head_t     head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    pdfe_pkg::plan_t       mem_reg [Depth];
    logic [PtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]       count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head.valid = (count_reg != '0);
    assign head.plan  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

/* rtl/pdfe_back.sv */
module pdfe_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdfe_pkg::q_head_t     head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_char,
    output logic                  run_end
);

    logic [pdfe_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [7:0]                 char_reg;
    logic                       end_reg;
    logic                       load;
    logic                       at_last;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign run_end   = end_reg;

    // A character moves into the output register whenever that register is free or drains.
    assign load    = head.valid && (!valid_reg || out_ready);
    assign at_last = (idx_reg == head.plan.cnt - pdfe_pkg::CNT_W'(1));
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + pdfe_pkg::CNT_W'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= head.plan.chars[idx_reg];
            end_reg  <= at_last;
        end
    end

endmodule

/* rtl/pdf_token_byte_escaper_core.sv */
// Channel  | Direction | Ports                          | Contents
// ---------+-----------+--------------------------------+----------------------------------
// s        | in        | s_tvalid s_tready s_tdata      | tdata: data_byte
//          |           | s_tuser s_tlast                | tuser: first_byte, tlast: last_byte
// m        | out       | m_tvalid m_tready m_tdata      | tdata: out_char
//          |           | m_tlast                        | tlast: run_end
// apb      | in/out    | psel penable pwrite paddr ...  | token_mode at address 0
//
// Each input item yields one to six characters, one per cycle out of the output register
// while the output is not stalled. The front part classifies an item in the cycle it is taken;
// when the queue was empty, the item is written into the queue and its first character is
// then loaded into the output register. The queue holds QueueDepth items, so input keeps
// flowing while the output is stalled until the queue is full.
// Reset empties the queue and the output register and sets the mode to literal string.
module pdf_token_byte_escaper_core #(
    parameter int QueueDepth = pdfe_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,
    // Configuration.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]            token_mode_reg, token_mode_next;
    logic                  q_full;
    logic                  push;
    logic                  pop;
    pdfe_pkg::plan_t       plan;
    pdfe_pkg::q_head_t     head;

    // Mode register behind the configuration port.
    assign pready = 1'b1;
    assign prdata = {30'd0, token_mode_reg};

    always_comb
    begin
        token_mode_next = token_mode_reg;
        if (psel && penable && pwrite && pready && (paddr == pdfe_pkg::ADDR_TOKEN_MODE))
        begin
            token_mode_next = pwdata[1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_mode_reg <= pdfe_pkg::MODE_LITERAL;
        end
        else
        begin
            token_mode_reg <= token_mode_next;
        end
    end

    pdfe_front u_front (
        .in_valid   (s_tvalid),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .token_mode (token_mode_reg),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (push),
        .plan       (plan)
    );

    pdfe_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_plan (plan),
        .full      (q_full),
        .pop       (pop),
        .head      (head)
    );

    pdfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .run_end   (m_tlast)
    );

endmodule

/* rtl/pdfe_checker.sv */
module pdfe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [1:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A stalled result holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // The input side only closes after it has taken an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input ready dropped without an accepted item");

    // A write to the mode register reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr == pdfe_pkg::ADDR_TOKEN_MODE)
            |=> prdata[1:0] == $past(pwdata[1:0]))
        else $error("mode register did not take the written value");

    // Only the two mode bits read back.
    assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:2] == 30'd0)
        else $error("unused read bits are set");

endmodule

bind pdf_token_byte_escaper_core pdfe_checker u_pdfe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
